>>> design/cna_pkg.sv
package cna_pkg;

    localparam int WORD_W  = 16;
    localparam int FRAC_W  = 12;
    localparam int CMD_W   = 4;
    localparam int EXP_W   = 4;
    localparam int OPND_W  = WORD_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int CX_W    = WORD_W + 4;
    localparam int ANG_W   = 34;
    localparam int ANG_FRAC = 30;
    localparam int ITER_W  = 4;
    localparam int GAIN_W  = 31;
    localparam int GPROD_W = CX_W + GAIN_W;
    localparam int SAT_IN_W = 48;
    localparam int Q_DEPTH = 2;

    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CONJ  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SCALE = 4'd4;
    localparam logic [CMD_W-1:0] CMD_POWER = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MAGSQ = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MAG   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_PHASE = 4'd8;

    localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q30 = 31'd652032874;
    localparam logic signed [WORD_W-1:0] ONE_Q = 16'sd4096;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_CONJ, OP_MUL, OP_POW, OP_MAG, OP_PHASE, OP_ZERO
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  a_re;
        logic signed [WORD_W-1:0]  a_im;
        logic signed [OPND_W-1:0]  b_re;
        logic signed [OPND_W-1:0]  b_im;
        logic [EXP_W-1:0]          exponent;
        logic signed [CX_W-1:0]    cx;
        logic signed [CX_W-1:0]    cy;
        logic signed [ANG_W-1:0]   cz;
        logic                      angle_fixed;
    } job_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic                     clip;
    } sat_t;

    function automatic sat_t sat_word(input logic signed [SAT_IN_W-1:0] v);
        sat_t r;
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(signed'({1'b0, {(WORD_W-1){1'b1}}}));
        lo = SAT_IN_W'(signed'({1'b1, {(WORD_W-1){1'b0}}}));
        if (v > hi) begin
            r.value = hi[WORD_W-1:0];
            r.clip  = 1'b1;
        end else if (v < lo) begin
            r.value = lo[WORD_W-1:0];
            r.clip  = 1'b1;
        end else begin
            r.value = v[WORD_W-1:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

    // arctan(2^-i) in Q30, truncated
    function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
        logic [29:0] r;
        unique case (i)
            4'd0:  r = 30'h3243F6A8;
            4'd1:  r = 30'h1DAC6705;
            4'd2:  r = 30'h0FADBAFC;
            4'd3:  r = 30'h07F56EA6;
            4'd4:  r = 30'h03FEAB76;
            4'd5:  r = 30'h01FFD55B;
            4'd6:  r = 30'h00FFFAAA;
            4'd7:  r = 30'h007FFF55;
            4'd8:  r = 30'h003FFFEA;
            4'd9:  r = 30'h001FFFFD;
            4'd10: r = 30'h000FFFFF;
            4'd11: r = 30'h0007FFFF;
            4'd12: r = 30'h0003FFFF;
            4'd13: r = 30'h0001FFFF;
            4'd14: r = 30'h0000FFFF;
            4'd15: r = 30'h00007FFF;
        endcase
        return r;
    endfunction

endpackage

>>> design/cna_front.sv
module cna_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cna_pkg::CMD_W-1:0]     cmd,
    input  logic signed [cna_pkg::WORD_W-1:0] a_re,
    input  logic signed [cna_pkg::WORD_W-1:0] a_im,
    input  logic signed [cna_pkg::WORD_W-1:0] b_re,
    input  logic signed [cna_pkg::WORD_W-1:0] b_im,
    input  logic signed [cna_pkg::WORD_W-1:0] scale_factor,
    input  logic [cna_pkg::EXP_W-1:0]     exponent,
    input  logic                          q_full,
    output logic                          q_push,
    output cna_pkg::job_t                 q_job
);
    import cna_pkg::*;

    logic signed [CX_W-1:0] ar_x;
    logic signed [CX_W-1:0] ai_x;

    assign ar_x     = CX_W'(a_re);
    assign ai_x     = CX_W'(a_im);
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_job             = '0;
        q_job.op          = OP_ZERO;
        q_job.a_re        = a_re;
        q_job.a_im        = a_im;
        q_job.b_re        = OPND_W'(b_re);
        q_job.b_im        = OPND_W'(b_im);
        q_job.exponent    = exponent;
        q_job.cx          = '0;
        q_job.cy          = '0;
        q_job.cz          = '0;
        q_job.angle_fixed = 1'b0;
        unique case (cmd)
            CMD_ADD:   q_job.op = OP_ADD;
            CMD_SUB:   q_job.op = OP_SUB;
            CMD_CONJ:  q_job.op = OP_CONJ;
            CMD_MUL:   q_job.op = OP_MUL;
            CMD_SCALE:
            begin
                // scaling is a product with (sf, 0)
                q_job.op   = OP_MUL;
                q_job.b_re = OPND_W'(scale_factor);
                q_job.b_im = '0;
            end
            CMD_POWER: q_job.op = OP_POW;
            CMD_MAGSQ:
            begin
                // a times conj(a): real part is |a|^2, imaginary part rounds to 0
                q_job.op   = OP_MUL;
                q_job.b_re = OPND_W'(a_re);
                q_job.b_im = -OPND_W'(a_im);
            end
            CMD_MAG:
            begin
                q_job.op = OP_MAG;
                q_job.cx = a_re[WORD_W-1] ? -ar_x : ar_x;
                q_job.cy = ai_x;
            end
            CMD_PHASE:
            begin
                q_job.op = OP_PHASE;
                if (a_im == '0) begin
                    q_job.angle_fixed = 1'b1;
                    q_job.cz = a_re[WORD_W-1] ? PI_Q30 : '0;
                end else if (a_re[WORD_W-1]) begin
                    // left half plane: turn by pi first
                    q_job.cx = -ar_x;
                    q_job.cy = -ai_x;
                    q_job.cz = (a_im > 0) ? PI_Q30 : -PI_Q30;
                end else begin
                    q_job.cx = ar_x;
                    q_job.cy = ai_x;
                end
            end
            default:   q_job.op = OP_ZERO;
        endcase
    end

endmodule

>>> design/cna_queue.sv
module cna_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cna_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output cna_pkg::job_t head,
    output logic          empty
);
    import cna_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    job_t               mem [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/cna_back.sv
module cna_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  cna_pkg::job_t                     q_head,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cna_pkg::WORD_W-1:0] res_re,
    output logic signed [cna_pkg::WORD_W-1:0] res_im,
    output logic                              saturated
);
    import cna_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_POW, S_POWM, S_POWA, S_CORDIC, S_GAIN, S_ROUND, S_DONE
    } state_t;

    state_t                     state_reg;
    state_t                     ret_reg;
    job_t                       job_reg;
    logic signed [WORD_W-1:0]   r_re_reg, r_im_reg;
    logic                       flag_reg;
    logic                       started_reg;
    logic [$clog2(EXP_W)-1:0]   bit_reg;
    logic [2:0]                 step_reg;
    logic signed [OPND_W-1:0]   u_re_reg, u_im_reg, v_re_reg, v_im_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    sat_t                       tmp_reg;
    logic signed [CX_W-1:0]     cx_reg, cy_reg;
    logic signed [ANG_W-1:0]    cz_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic signed [GPROD_W-1:0]  gain_reg;
    logic                       out_valid_reg;
    logic signed [WORD_W-1:0]   res_re_reg, res_im_reg;
    logic                       sat_reg;

    logic signed [OPND_W-1:0]   m_a, m_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    acc_rnd;
    sat_t                       acc_sat;
    sat_t                       fin_sat;
    logic signed [CX_W-1:0]     dx, dy;
    logic signed [ANG_W-1:0]    ang;
    sat_t                       add_re, add_im, sub_re, sub_im, neg_im;
    sat_t                       gain_sat, phase_sat;
    logic                       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign saturated = sat_reg;

    // one shared multiplier walks the four partial products of a complex multiply
    always_comb
    begin
        unique case (step_reg[1:0])
            2'd0:    begin m_a = u_re_reg; m_b = v_re_reg; end
            2'd1:    begin m_a = u_im_reg; m_b = v_im_reg; end
            2'd2:    begin m_a = u_re_reg; m_b = v_im_reg; end
            default: begin m_a = u_im_reg; m_b = v_re_reg; end
        endcase
    end

    assign prod    = m_a * m_b;
    assign acc_rnd = (acc_reg + ACC_W'(1 <<< (FRAC_W - 1))) >>> FRAC_W;
    assign acc_sat = sat_word(SAT_IN_W'(acc_rnd));
    assign fin_sat = acc_sat;

    assign dx  = cy_reg >>> iter_reg;
    assign dy  = cx_reg >>> iter_reg;
    assign ang = ANG_W'(atan_q30(iter_reg));

    assign add_re = sat_word(SAT_IN_W'(q_head.a_re) + SAT_IN_W'(q_head.b_re));
    assign add_im = sat_word(SAT_IN_W'(q_head.a_im) + SAT_IN_W'(q_head.b_im));
    assign sub_re = sat_word(SAT_IN_W'(q_head.a_re) - SAT_IN_W'(q_head.b_re));
    assign sub_im = sat_word(SAT_IN_W'(q_head.a_im) - SAT_IN_W'(q_head.b_im));
    assign neg_im = sat_word(-SAT_IN_W'(q_head.a_im));

    assign gain_sat = sat_word(SAT_IN_W'((gain_reg + GPROD_W'(1 <<< (ANG_FRAC - 1)))
                                         >>> ANG_FRAC));
    assign phase_sat = sat_word(SAT_IN_W'((cz_reg + ANG_W'(1 <<< (ANG_FRAC - FRAC_W - 1)))
                                          >>> (ANG_FRAC - FRAC_W)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_DONE;
            job_reg       <= '0;
            r_re_reg      <= '0;
            r_im_reg      <= '0;
            flag_reg      <= 1'b0;
            started_reg   <= 1'b0;
            bit_reg       <= '0;
            step_reg      <= '0;
            u_re_reg      <= '0;
            u_im_reg      <= '0;
            v_re_reg      <= '0;
            v_im_reg      <= '0;
            acc_reg       <= '0;
            tmp_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            iter_reg      <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_re_reg    <= '0;
            res_im_reg    <= '0;
            sat_reg       <= 1'b0;
        end else begin
            if (out_valid_reg && !out_stall && (state_reg != S_DONE)) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty) begin
                        job_reg  <= q_head;
                        unique case (q_head.op)
                            OP_ADD:
                            begin
                                r_re_reg  <= add_re.value;
                                r_im_reg  <= add_im.value;
                                flag_reg  <= add_re.clip | add_im.clip;
                                state_reg <= S_DONE;
                            end
                            OP_SUB:
                            begin
                                r_re_reg  <= sub_re.value;
                                r_im_reg  <= sub_im.value;
                                flag_reg  <= sub_re.clip | sub_im.clip;
                                state_reg <= S_DONE;
                            end
                            OP_CONJ:
                            begin
                                r_re_reg  <= q_head.a_re;
                                r_im_reg  <= neg_im.value;
                                flag_reg  <= neg_im.clip;
                                state_reg <= S_DONE;
                            end
                            OP_MUL:
                            begin
                                flag_reg  <= 1'b0;
                                u_re_reg  <= OPND_W'(q_head.a_re);
                                u_im_reg  <= OPND_W'(q_head.a_im);
                                v_re_reg  <= q_head.b_re;
                                v_im_reg  <= q_head.b_im;
                                step_reg  <= '0;
                                ret_reg   <= S_DONE;
                                state_reg <= S_MAC;
                            end
                            OP_POW:
                            begin
                                flag_reg    <= 1'b0;
                                r_re_reg    <= ONE_Q;
                                r_im_reg    <= '0;
                                started_reg <= 1'b0;
                                bit_reg     <= ($clog2(EXP_W))'(EXP_W - 1);
                                state_reg   <= S_POW;
                            end
                            OP_MAG, OP_PHASE:
                            begin
                                flag_reg  <= 1'b0;
                                cx_reg    <= q_head.cx;
                                cy_reg    <= q_head.cy;
                                cz_reg    <= q_head.cz;
                                iter_reg  <= '0;
                                state_reg <= q_head.angle_fixed ? S_ROUND : S_CORDIC;
                            end
                            OP_ZERO:
                            begin
                                flag_reg  <= 1'b0;
                                r_re_reg  <= '0;
                                r_im_reg  <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_MAC:
                begin
                    step_reg <= step_reg + 1'b1;
                    unique case (step_reg)
                        3'd0: acc_reg <= ACC_W'(prod);
                        3'd1: acc_reg <= acc_reg - ACC_W'(prod);
                        3'd2:
                        begin
                            tmp_reg <= acc_sat;
                            acc_reg <= ACC_W'(prod);
                        end
                        3'd3: acc_reg <= acc_reg + ACC_W'(prod);
                        default:
                        begin
                            r_re_reg  <= tmp_reg.value;
                            r_im_reg  <= fin_sat.value;
                            flag_reg  <= flag_reg | tmp_reg.clip | fin_sat.clip;
                            state_reg <= ret_reg;
                        end
                    endcase
                end

                S_POW:
                begin
                    if (started_reg) begin
                        u_re_reg  <= OPND_W'(r_re_reg);
                        u_im_reg  <= OPND_W'(r_im_reg);
                        v_re_reg  <= OPND_W'(r_re_reg);
                        v_im_reg  <= OPND_W'(r_im_reg);
                        step_reg  <= '0;
                        ret_reg   <= S_POWM;
                        state_reg <= S_MAC;
                    end else begin
                        // leading one loads a without rounding
                        if (job_reg.exponent[bit_reg]) begin
                            r_re_reg    <= job_reg.a_re;
                            r_im_reg    <= job_reg.a_im;
                            started_reg <= 1'b1;
                        end
                        if (bit_reg == '0) begin
                            state_reg <= S_DONE;
                        end else begin
                            bit_reg <= bit_reg - 1'b1;
                        end
                    end
                end

                S_POWM:
                begin
                    if (job_reg.exponent[bit_reg]) begin
                        u_re_reg  <= OPND_W'(r_re_reg);
                        u_im_reg  <= OPND_W'(r_im_reg);
                        v_re_reg  <= OPND_W'(job_reg.a_re);
                        v_im_reg  <= OPND_W'(job_reg.a_im);
                        step_reg  <= '0;
                        ret_reg   <= S_POWA;
                        state_reg <= S_MAC;
                    end else begin
                        state_reg <= S_POWA;
                    end
                end

                S_POWA:
                begin
                    if (bit_reg == '0) begin
                        state_reg <= S_DONE;
                    end else begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= S_POW;
                    end
                end

                S_CORDIC:
                begin
                    if (!cy_reg[CX_W-1]) begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + ang;
                    end else begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - ang;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == {ITER_W{1'b1}}) begin
                        state_reg <= (job_reg.op == OP_MAG) ? S_GAIN : S_ROUND;
                    end
                end

                S_GAIN:
                begin
                    gain_reg  <= GPROD_W'(cx_reg) * GPROD_W'(signed'({1'b0, INV_GAIN_Q30}));
                    state_reg <= S_ROUND;
                end

                S_ROUND:
                begin
                    r_im_reg <= '0;
                    if (job_reg.op == OP_MAG) begin
                        r_re_reg <= gain_sat.value;
                        flag_reg <= gain_sat.clip;
                    end else begin
                        r_re_reg <= phase_sat.value;
                        flag_reg <= phase_sat.clip;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        res_re_reg    <= r_re_reg;
                        res_im_reg    <= r_im_reg;
                        sat_reg       <= flag_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/complex_number_alu_core.sv
// Complex arithmetic unit on Q4.12 words: add, sub, multiply, conjugate, real scale,
// integer power, squared magnitude, and CORDIC magnitude and phase, each result
// saturated with a clip flag. A front decoder classifies each transaction into a
// two-entry queue; the back engine runs one transaction at a time on a single shared
// 17x17 multiplier and a 16-step CORDIC. Unknown codes return zero, a phase on the real
// axis skips the CORDIC, and integer power squares once per exponent bit after the
// leading one and multiplies by a once per further set bit.
module complex_number_alu_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cna_pkg::CMD_W-1:0]         cmd,
    input  logic signed [cna_pkg::WORD_W-1:0] a_re,
    input  logic signed [cna_pkg::WORD_W-1:0] a_im,
    input  logic signed [cna_pkg::WORD_W-1:0] b_re,
    input  logic signed [cna_pkg::WORD_W-1:0] b_im,
    input  logic signed [cna_pkg::WORD_W-1:0] scale_factor,
    input  logic [cna_pkg::EXP_W-1:0]         exponent,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cna_pkg::WORD_W-1:0] res_re,
    output logic signed [cna_pkg::WORD_W-1:0] res_im,
    output logic                              saturated
);
    import cna_pkg::*;

    logic q_full, q_push, q_pop, q_empty;
    job_t q_job, q_head;

    cna_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .a_re         (a_re),
        .a_im         (a_im),
        .b_re         (b_re),
        .b_im         (b_im),
        .scale_factor (scale_factor),
        .exponent     (exponent),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    cna_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    cna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .saturated (saturated)
    );

endmodule

>>> tb/sv/tb_complex_number_alu_core.sv
`timescale 1ns / 1ps

module tb_complex_number_alu_core;
    import cna_pkg::*;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               clip;
    } cx_result_t;

    int n_errors = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    // reference arithmetic
    function automatic longint sh_r(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint clip_word(input longint v, inout logic f);
        if (v > 32767) begin
            f = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            f = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint rnd_q(input longint p);
        return sh_r(p + 2048, 12);
    endfunction

    function automatic void cx_mul(input longint ar, input longint ai, input longint br,
                                   input longint bi, output longint rr, output longint ri,
                                   inout logic f);
        rr = clip_word(rnd_q(ar * br - ai * bi), f);
        ri = clip_word(rnd_q(ar * bi + ai * br), f);
    endfunction

    function automatic longint arctan_tab(input int i);
        return longint'(atan_q30(i[3:0]));
    endfunction

    function automatic longint cordic_vec(input longint x0, input longint y0, inout longint z);
        longint x, y, dx, dy;
        x = x0;
        y = y0;
        for (int i = 0; i < 16; i++) begin
            dx = sh_r(y, i);
            dy = sh_r(x, i);
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += arctan_tab(i);
            end else begin
                x -= dx;
                y += dy;
                z -= arctan_tab(i);
            end
        end
        return x;
    endfunction

    function automatic cx_result_t alu_predict(input logic [3:0] c, input logic signed [15:0] a_r,
                                               input logic signed [15:0] a_i,
                                               input logic signed [15:0] b_r,
                                               input logic signed [15:0] b_i,
                                               input logic signed [15:0] sf,
                                               input logic [3:0] ex);
        cx_result_t r;
        longint ar, ai, br, bi, rr, ri, z, x, pi_q;
        logic f;
        bit started;
        ar = a_r;
        ai = a_i;
        br = b_r;
        bi = b_i;
        rr = 0;
        ri = 0;
        z = 0;
        f = 1'b0;
        started = 0;
        pi_q = longint'(PI_Q30);
        case (c)
            CMD_ADD: begin
                rr = clip_word(ar + br, f);
                ri = clip_word(ai + bi, f);
            end
            CMD_SUB: begin
                rr = clip_word(ar - br, f);
                ri = clip_word(ai - bi, f);
            end
            CMD_MUL: cx_mul(ar, ai, br, bi, rr, ri, f);
            CMD_CONJ: begin
                rr = ar;
                ri = clip_word(-ai, f);
            end
            CMD_SCALE: begin
                rr = clip_word(rnd_q(ar * longint'(sf)), f);
                ri = clip_word(rnd_q(ai * longint'(sf)), f);
            end
            CMD_POWER: begin
                rr = 4096;
                ri = 0;
                for (int b = 3; b >= 0; b--) begin
                    if (started) cx_mul(rr, ri, rr, ri, rr, ri, f);
                    if (ex[b]) begin
                        if (started) cx_mul(rr, ri, ar, ai, rr, ri, f);
                        else begin
                            rr = ar;
                            ri = ai;
                            started = 1;
                        end
                    end
                end
            end
            CMD_MAGSQ: rr = clip_word(sh_r(ar * ar + ai * ai + 2048, 12), f);
            CMD_MAG: begin
                x = cordic_vec(ar < 0 ? -ar : ar, ai, z);
                rr = clip_word(sh_r(x * longint'(INV_GAIN_Q30) + (64'sd1 <<< 29), 30), f);
            end
            CMD_PHASE: begin
                if (ai == 0) z = ar < 0 ? pi_q : 0;
                else if (ar < 0) begin
                    z = ai > 0 ? pi_q : -pi_q;
                    void'(cordic_vec(-ar, -ai, z));
                end else void'(cordic_vec(ar, ai, z));
                rr = clip_word(sh_r(z + (64'sd1 <<< 17), 18), f);
            end
            default: ;
        endcase
        r.re = rr[15:0];
        r.im = ri[15:0];
        r.clip = f;
        return r;
    endfunction

    class alu_scoreboard;
        cx_result_t pending[$];

        function void note_operands(logic [3:0] c, logic signed [15:0] ar, logic signed [15:0] ai,
                                    logic signed [15:0] br, logic signed [15:0] bi,
                                    logic signed [15:0] sf, logic [3:0] ex);
            pending.push_back(alu_predict(c, ar, ai, br, bi, sf, ex));
        endfunction

        task check_result(logic signed [15:0] re, logic signed [15:0] im, logic s);
            cx_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result re", re, 0);
                return;
            end
            w = pending.pop_front();
            if (re !== w.re) report_mismatch("res_re", re, w.re);
            if (im !== w.im) report_mismatch("res_im", im, w.im);
            if (s !== w.clip) report_mismatch("saturated", s, w.clip);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] cmd = '0;
    logic signed [15:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0, scale_factor = '0;
    logic [3:0] exponent = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] res_re, res_im;
    logic saturated;

    int send_idle_pct = 26;
    int recv_idle_pct = 46;
    bit hold_recv = 0;
    bit stim_done = 0;
    int n_results = 0;
    alu_scoreboard sb = new();

    complex_number_alu_core uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_operands(cmd, a_re, a_im, b_re, b_im, scale_factor, exponent);
        if (rst_n && out_valid && !out_stall) begin
            sb.check_result(res_re, res_im, saturated);
            n_results++;
        end
    end

    // receiver stall process
    always @(posedge clk) begin
        if (hold_recv) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(8192)) - 4096);
            4: return 16'h1000;
            5: return 16'hF000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [3:0] c, input logic [15:0] ar, input logic [15:0] ai,
                             input logic [15:0] br, input logic [15:0] bi, input logic [15:0] sf,
                             input logic [3:0] ex);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        a_re <= ar;
        a_im <= ai;
        b_re <= br;
        b_im <= bi;
        scale_factor <= sf;
        exponent <= ex;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_random();
        logic [3:0] c;
        c = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        send_item(c, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                  4'($urandom));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed corners
        send_item(CMD_ADD, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 0, 0);
        send_item(CMD_SUB, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 0, 0);
        send_item(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 0, 0);
        send_item(CMD_MUL, 16'h1000, 16'h0800, 16'hF800, 16'h1000, 0, 0);
        send_item(CMD_CONJ, 16'h1234, 16'h8000, 0, 0, 0, 0);
        send_item(CMD_SCALE, 16'h7FFF, 16'h8000, 0, 0, 16'h8000, 0);
        send_item(CMD_SCALE, 16'h0800, 16'hF801, 0, 0, 16'h0001, 0);
        send_item(CMD_POWER, 16'h1234, 16'h5678, 0, 0, 0, 4'd0);
        send_item(CMD_POWER, 16'h0F00, 16'h0300, 0, 0, 0, 4'd15);
        send_item(CMD_POWER, 16'h1100, 16'hF000, 0, 0, 0, 4'd1);
        send_item(CMD_POWER, 16'h7FFF, 16'h7FFF, 0, 0, 0, 4'd8);
        send_item(CMD_MAGSQ, 16'h8000, 16'h8000, 0, 0, 0, 0);
        send_item(CMD_MAGSQ, 16'h0400, 16'hFC00, 0, 0, 0, 0);
        send_item(CMD_MAG, 16'h8000, 16'h7FFF, 0, 0, 0, 0);
        send_item(CMD_MAG, 16'h0000, 16'h0000, 0, 0, 0, 0);
        send_item(CMD_PHASE, 16'h0000, 16'h0000, 0, 0, 0, 0);
        send_item(CMD_PHASE, 16'hF000, 16'h0000, 0, 0, 0, 0);
        send_item(CMD_PHASE, 16'h1000, 16'h0000, 0, 0, 0, 0);
        send_item(CMD_PHASE, 16'hF000, 16'h0001, 0, 0, 0, 0);
        send_item(CMD_PHASE, 16'h8000, 16'hFFFF, 0, 0, 0, 0);
        send_item(CMD_PHASE, 16'h7FFF, 16'h8000, 0, 0, 0, 0);
        send_item(4'd9, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF);
        send_item(4'd15, 0, 0, 0, 0, 0, 0);
        // sender pauses until everything is back
        drain();
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_recv = 1;
                repeat (120) @(posedge clk);
                hold_recv = 0;
            end
            repeat (10) send_random();
        join
        repeat (400) send_random();
        send_idle_pct = 46;
        recv_idle_pct = 26;
        repeat (400) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (420) send_random();
        drain();
        repeat (60) @(posedge clk);
        $display("covered all nine commands, unknown codes, saturation corners, %0d results",
                 n_results);
        $display("under sender and receiver idling and a long receiver hold-off");
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("[complex_number_alu_core] OK");
        else
            $display("[complex_number_alu_core] ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("[complex_number_alu_core] ERROR");
        $finish;
    end
endmodule

>>> sim.f
design/cna_pkg.sv
design/cna_front.sv
design/cna_queue.sv
design/cna_back.sv
design/complex_number_alu_core.sv
tb/sv/tb_complex_number_alu_core.sv
